/* rtl/mss_pkg.sv */
// Package for the shared-store multi-stack block.
// Holds request/status codes, fixed field widths and controller/datapath structs.
// Used by mss_ctrl, mss_dpath and multi_stack_shared_store.
package mss_pkg;

	// fixed field widths
	localparam int ITEM_W = 32;
	localparam int SID_W  = 3;
	localparam int STAT_W = 2;

	// request kinds
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic accept;   // capture request, read top and free-head link
		logic cell_rd;  // pop: read value and link of the top cell
		logic fin_top;  // finish after top read (push, or empty pop)
		logic fin_pop;  // finish a pop after the cell read
	} mss_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_pop;
		logic top_null;
	} mss_stat_t;

endpackage

/* rtl/multi_stack_shared_store.sv */
// A push, or a pop of an empty stack, loads its result beat at the top-read
// step; a pop of a non-empty stack first does a further synchronous read, of
// the top cell's value and link. A new request is taken only once the last is
// done, as free head and top move only after the registered link memory read.
// Reset: free head 0, all stacks empty; untouched cells are tracked by a
// watermark, so no clearing pass is needed and requests are taken at once.
module multi_stack_shared_store
	import mss_pkg::*;
#(
	parameter int CELLS  = 64,
	parameter int STACKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [2:0] stack_id, [34:3] item, rest zero
	input  logic [0:0]  s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [31:0] popped_value, [33:32] status, rest zero
);

	mss_cmd_t          cmd;
	mss_stat_t         stat;
	logic [ITEM_W-1:0] popped_value;
	logic [STAT_W-1:0] status;

	mss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mss_dpath #(
		.CELLS  (CELLS),
		.STACKS (STACKS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_req_type  (s_tuser[0]),
		.in_stack_id  (s_tdata[SID_W-1:0]),
		.in_item      (s_tdata[SID_W+ITEM_W-1:SID_W]),
		.popped_value (popped_value),
		.status       (status)
	);

	// output beat packing
	assign m_tdata = {6'd0, status, popped_value};

endmodule

/* rtl/mss_ctrl.sv */
// Controller for the shared-store multi-stack block: request sequencing and
// output-beat valid. Depends on mss_pkg.
module mss_ctrl
	import mss_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  mss_stat_t stat,
	output mss_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_TOP  = 3'b010,
		S_POP  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// output slot can take a result this cycle
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_TOP;
				end
			end
			S_TOP: begin
				if (stat.is_pop && !stat.top_null) begin
					cmd.cell_rd = 1'b1;
					state_d     = S_POP;
				end else if (out_free) begin
					cmd.fin_top = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_POP: begin
				if (out_free) begin
					cmd.fin_pop = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fin_top || cmd.fin_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a result never overwrites a beat that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin_top || cmd.fin_pop) |-> (!out_valid_q || out_ready))
		else $error("result loaded over a pending output beat");

	// the cell read is only issued for a pop of a non-empty stack
	a_cell_rd_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cell_rd |-> (stat.is_pop && !stat.top_null))
		else $error("cell read issued for a push or an empty stack");

	// an accepted request always moves to the top-read step
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == S_TOP))
		else $error("accepted request did not reach top-read step");

	// a pop finish is always preceded by its cell read
	a_pop_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_pop |-> (state_q == S_POP))
		else $error("pop finished outside the pop step");

endmodule

/* rtl/mss_dpath.sv */
// Datapath for the shared-store multi-stack block: cell value/link memories,
// stack-top memory with valid bits, free head and fresh-cell watermark.
// Depends on mss_pkg.
module mss_dpath
	import mss_pkg::*;
#(
	parameter int CELLS  = 64,
	parameter int STACKS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mss_cmd_t          cmd,
	output mss_stat_t         stat,
	input  logic              in_req_type,
	input  logic [SID_W-1:0]  in_stack_id,
	input  logic [ITEM_W-1:0] in_item,
	output logic [ITEM_W-1:0] popped_value,
	output logic [STAT_W-1:0] status
);

	localparam int CW     = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int LW     = $clog2(CELLS + 1);
	localparam int SIDX_W = (STACKS > 1) ? $clog2(STACKS) : 1;
	localparam int SEL_W  = (SIDX_W > SID_W) ? SIDX_W : SID_W;
	localparam logic [LW-1:0] NULL_LINK = LW'(CELLS);

	// storage
	logic [ITEM_W-1:0] val_mem [CELLS];
	logic [LW-1:0]     lnk_mem [CELLS];
	logic [LW-1:0]     top_mem [STACKS];
	logic [STACKS-1:0] top_vld_q;
	logic [LW-1:0]     fh_q;
	logic [LW-1:0]     hwm_q;

	// request and read-data registers
	logic              req_q;
	logic [SIDX_W-1:0] idx_q;
	logic              have_q;
	logic [ITEM_W-1:0] item_q;
	logic [LW-1:0]     top_rd_s1;
	logic              top_vld_s1;
	logic [LW-1:0]     lnk_rd_s1;
	logic [CW-1:0]     lnk_addr_s1;
	logic [ITEM_W-1:0] val_rd_s1;
	logic [ITEM_W-1:0] pop_val_q;
	logic [STAT_W-1:0] status_q;

	logic [SEL_W-1:0]  sid_ext;
	logic [SIDX_W-1:0] in_idx;
	logic              in_have;
	logic [LW-1:0]     top_cur;
	logic [LW-1:0]     link_eff;
	logic              push_ok;
	logic              do_push;
	logic [CW-1:0]     fh_addr;
	logic [CW-1:0]     top_addr;
	logic              lnk_we;
	logic [CW-1:0]     lnk_wa;
	logic [LW-1:0]     lnk_wd;
	logic [CW-1:0]     lnk_ra;
	logic              top_we;
	logic [LW-1:0]     top_wd;

	// request decode
	assign sid_ext = SEL_W'(in_stack_id);
	assign in_idx  = sid_ext[SIDX_W-1:0];
	assign in_have = (32'(in_stack_id) < STACKS);

	assign fh_addr  = fh_q[CW-1:0];
	assign top_cur  = top_vld_s1 ? top_rd_s1 : NULL_LINK;
	assign top_addr = top_cur[CW-1:0];

	// cells at or above the watermark were never written: link is index+1
	assign link_eff = (LW'(lnk_addr_s1) >= hwm_q) ? (LW'(lnk_addr_s1) + LW'(1)) : lnk_rd_s1;

	assign push_ok = have_q && (fh_q != NULL_LINK);
	assign do_push = cmd.fin_top && (req_q == REQ_PUSH) && push_ok;

	assign stat.is_pop   = (req_q == REQ_POP);
	assign stat.top_null = (top_cur == NULL_LINK);

	// link memory port muxing
	assign lnk_ra = cmd.cell_rd ? top_addr : fh_addr;
	assign lnk_we = do_push || cmd.fin_pop;
	assign lnk_wa = do_push ? fh_addr : top_addr;
	assign lnk_wd = do_push ? top_cur : fh_q;

	// top memory write
	assign top_we = do_push || cmd.fin_pop;
	assign top_wd = do_push ? fh_q : link_eff;

	// cell value memory
	always_ff @(posedge clk) begin
		if (do_push) begin
			val_mem[fh_addr] <= item_q;
		end
		if (cmd.cell_rd) begin
			val_rd_s1 <= val_mem[top_addr];
		end
	end

	// cell link memory
	always_ff @(posedge clk) begin
		if (lnk_we) begin
			lnk_mem[lnk_wa] <= lnk_wd;
		end
		if (cmd.accept || cmd.cell_rd) begin
			lnk_rd_s1   <= lnk_mem[lnk_ra];
			lnk_addr_s1 <= lnk_ra;
		end
	end

	// stack top memory
	always_ff @(posedge clk) begin
		if (top_we) begin
			top_mem[idx_q] <= top_wd;
		end
		if (cmd.accept) begin
			top_rd_s1 <= top_mem[in_idx];
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q  <= in_req_type;
			idx_q  <= in_idx;
			have_q <= in_have;
			item_q <= in_item;
		end
		if (cmd.fin_top) begin
			pop_val_q <= '0;
			if (req_q == REQ_POP) begin
				status_q <= ST_EMPTY;
			end else if (push_ok) begin
				status_q <= ST_OK;
			end else begin
				status_q <= ST_FULL;
			end
		end else if (cmd.fin_pop) begin
			pop_val_q <= val_rd_s1;
			status_q  <= ST_OK;
		end
	end

	// control state: free head, watermark, top valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fh_q       <= '0;
			hwm_q      <= '0;
			top_vld_q  <= '0;
			top_vld_s1 <= 1'b0;
		end else begin
			if (cmd.accept) begin
				top_vld_s1 <= in_have && top_vld_q[in_idx];
			end
			if (do_push) begin
				fh_q             <= link_eff;
				top_vld_q[idx_q] <= 1'b1;
				if (fh_q == hwm_q) begin
					hwm_q <= hwm_q + LW'(1);
				end
			end else if (cmd.fin_pop) begin
				fh_q <= top_cur;
			end
		end
	end

	assign popped_value = pop_val_q;
	assign status       = status_q;

endmodule
